// ----- rtl/twc_pkg.sv -----
// Shared types and constants for the triangle waterline clipper.
// Used by the job channel interface and by every module of the block.
package twc_pkg;

   // Kind of submerged piece that a sorted triangle yields.
   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_ALL,
      CLS_ONE,
      CLS_TWO
   } class_type;

   localparam int FRAC_BITS = 16;
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam int NAXES     = 3;
   localparam int NPOS      = 9;
   // Offsets of the high, middle and low vertex in a packed position group.
   localparam int VH = 0;
   localparam int VM = 3;
   localparam int VL = 6;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ----- rtl/twc_if.sv -----
// Channel interfaces of the triangle waterline clipper: triangles in,
// classified jobs between front and back, subtriangles out. Uses twc_pkg.
interface twc_req_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z, a_height;
   logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z, b_height;
   logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z, c_height;

   modport source (output valid, a_x, a_y, a_z, a_height, b_x, b_y, b_z, b_height,
                   c_x, c_y, c_z, c_height, input ready);
   modport sink (input valid, a_x, a_y, a_z, a_height, b_x, b_y, b_z, b_height,
                 c_x, c_y, c_z, c_height, output ready);
endinterface

interface twc_job_if #(parameter int COORD_WIDTH = 32);
   import twc_pkg::*;
   logic valid;
   logic ready;
   class_type cls;
   logic [NPOS-1:0][COORD_WIDTH-1:0] pos;
   logic [1:0][COORD_WIDTH-1:0] num;
   logic [1:0][COORD_WIDTH-1:0] den;

   modport source (output valid, cls, pos, num, den, input ready);
   modport sink (input valid, cls, pos, num, den, output ready);
endinterface

interface twc_rsp_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
   logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
   logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
   logic last_piece;

   modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   last_piece, input ready);
   modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 last_piece, output ready);
endinterface

// ----- rtl/twc_front.sv -----
// Front end: accepts a triangle, sorts its vertices by height, classifies
// it and prepares the cut fractions' operands. Uses twc_pkg and twc_if.
module twc_front #(
   parameter int COORD_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   twc_req_if.sink req,
   twc_job_if.source job
);
   import twc_pkg::*;

   localparam int W = COORD_WIDTH;

   logic [3:0][W-1:0] hv, mv, lv, tv;
   class_type cls;
   logic [W-1:0] lo0, hi0;
   logic [NPOS-1:0][W-1:0] pos;
   logic [1:0][W-1:0] num, den;

   logic vld_ff, vld_in;
   class_type cls_ff;
   logic [NPOS-1:0][W-1:0] pos_ff;
   logic [1:0][W-1:0] num_ff, den_ff;

   always_comb begin
      tv = '0;
      hv = {req.a_height, req.a_z, req.a_y, req.a_x};
      mv = {req.b_height, req.b_z, req.b_y, req.b_x};
      lv = {req.c_height, req.c_z, req.c_y, req.c_x};
      // Strict compares leave vertices of equal height in place.
      if ($signed(lv[3]) > $signed(hv[3])) begin
         tv = lv; lv = hv; hv = tv;
      end
      if ($signed(lv[3]) > $signed(mv[3])) begin
         tv = lv; lv = mv; mv = tv;
      end
      if ($signed(mv[3]) > $signed(hv[3])) begin
         tv = mv; mv = hv; hv = tv;
      end

      if (!lv[3][W-1]) begin
         cls = CLS_NONE;
      end else if (!mv[3][W-1]) begin
         cls = CLS_ONE;
      end else if (!hv[3][W-1]) begin
         cls = CLS_TWO;
      end else begin
         cls = CLS_ALL;
      end

      lo0 = (cls == CLS_TWO) ? mv[3] : lv[3];
      hi0 = (cls == CLS_TWO) ? hv[3] : mv[3];
      num[0] = '0 - lo0;
      den[0] = hi0 - lo0;
      num[1] = '0 - lv[3];
      den[1] = hv[3] - lv[3];

      for (int a = 0; a < NAXES; a++) begin
         pos[VH + a] = hv[a];
         pos[VM + a] = mv[a];
         pos[VL + a] = lv[a];
      end
   end

   assign req.ready = !vld_ff || job.ready;

   always_comb begin
      vld_in = vld_ff;
      if (job.valid && job.ready) begin
         vld_in = 1'b0;
      end
      // Triangles entirely above the water produce nothing and end here.
      if (req.valid && req.ready) begin
         vld_in = (cls != CLS_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cls_ff <= cls;
         pos_ff <= pos;
         num_ff <= num;
         den_ff <= den;
      end
   end

   assign job.valid = vld_ff;
   assign job.cls   = cls_ff;
   assign job.pos   = pos_ff;
   assign job.num   = num_ff;
   assign job.den   = den_ff;

endmodule

// ----- rtl/twc_queue.sv -----
// Short first-in first-out queue of classified jobs between the front end
// and the back end. Uses twc_pkg and twc_if.
module twc_queue #(
   parameter int COORD_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   twc_job_if.sink wr,
   twc_job_if.source rd
);
   import twc_pkg::*;

   localparam int W = COORD_WIDTH;

   class_type cls_mem [QDEPTH];
   logic [NPOS-1:0][W-1:0] pos_mem [QDEPTH];
   logic [1:0][W-1:0] num_mem [QDEPTH];
   logic [1:0][W-1:0] den_mem [QDEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign wr.ready = (count_ff != QCNT_W'(QDEPTH));
   assign rd.valid = (count_ff != '0);
   assign push = wr.valid && wr.ready;
   assign pop  = rd.valid && rd.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cls_mem[wr_ptr_ff] <= wr.cls;
         pos_mem[wr_ptr_ff] <= wr.pos;
         num_mem[wr_ptr_ff] <= wr.num;
         den_mem[wr_ptr_ff] <= wr.den;
      end
   end

   assign rd.cls = cls_mem[rd_ptr_ff];
   assign rd.pos = pos_mem[rd_ptr_ff];
   assign rd.num = num_mem[rd_ptr_ff];
   assign rd.den = den_mem[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue fill count exceeds its depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count missed a push");
`endif

endmodule

// ----- rtl/twc_back.sv -----
// Back end: pipelined cut-fraction dividers, edge interpolation and the
// result register that emits one or two subtriangles. Uses twc_pkg and twc_if.
module twc_back #(
   parameter int COORD_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   twc_job_if.sink job,
   twc_rsp_if.source rsp
);
   import twc_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int NDIV = FRAC_W;

   logic adv;

   // Divider stages: one quotient bit of each of the two fractions per stage.
   logic src_vld [NDIV];
   class_type src_cls [NDIV];
   logic [NPOS-1:0][W-1:0] src_pos [NDIV];
   logic [1:0][W-1:0] src_den [NDIV];
   logic [1:0][W:0] src_trial [NDIV];
   logic [1:0][FRAC_W-1:0] src_q [NDIV];
   logic [1:0] div_ge [NDIV];
   logic [1:0][W-1:0] rem_nx [NDIV];
   logic [1:0][FRAC_W-1:0] q_nx [NDIV];

   logic div_vld_ff [NDIV];
   class_type div_cls_ff [NDIV];
   logic [NPOS-1:0][W-1:0] div_pos_ff [NDIV];
   logic [1:0][W-1:0] div_den_ff [NDIV];
   logic [1:0][W-1:0] div_rem_ff [NDIV];
   logic [1:0][FRAC_W-1:0] div_q_ff [NDIV];

   always_comb begin
      src_vld[0] = job.valid;
      src_cls[0] = job.cls;
      src_pos[0] = job.pos;
      src_den[0] = job.den;
      for (int e = 0; e < 2; e++) begin
         src_trial[0][e] = {1'b0, job.num[e]};
         src_q[0][e]     = '0;
      end
      for (int k = 1; k < NDIV; k++) begin
         src_vld[k] = div_vld_ff[k-1];
         src_cls[k] = div_cls_ff[k-1];
         src_pos[k] = div_pos_ff[k-1];
         src_den[k] = div_den_ff[k-1];
         for (int e = 0; e < 2; e++) begin
            src_trial[k][e] = {div_rem_ff[k-1][e], 1'b0};
            src_q[k][e]     = div_q_ff[k-1][e];
         end
      end
      for (int k = 0; k < NDIV; k++) begin
         for (int e = 0; e < 2; e++) begin
            div_ge[k][e] = (src_trial[k][e] >= {1'b0, src_den[k][e]});
            rem_nx[k][e] = div_ge[k][e] ? W'(src_trial[k][e] - {1'b0, src_den[k][e]})
                                        : src_trial[k][e][W-1:0];
            q_nx[k][e]   = {src_q[k][e][FRAC_W-2:0], div_ge[k][e]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NDIV; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < NDIV; k++) begin
            div_vld_ff[k] <= src_vld[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NDIV; k++) begin
            div_cls_ff[k] <= src_cls[k];
            div_pos_ff[k] <= src_pos[k];
            div_den_ff[k] <= src_den[k];
            div_rem_ff[k] <= rem_nx[k];
            div_q_ff[k]   <= q_nx[k];
         end
      end
   end

   // Edge differences: sign and magnitude of end minus start per axis.
   logic dif_vld_ff;
   class_type dif_cls_ff;
   logic [NPOS-1:0][W-1:0] dif_pos_ff;
   logic [1:0][FRAC_W-1:0] dif_t_ff;
   logic [1:0][NAXES-1:0] dif_neg_ff, dif_neg_in;
   logic [1:0][NAXES-1:0][W-1:0] dif_mag_ff, dif_mag_in;
   logic [1:0][NAXES-1:0][W:0] dif_d;
   logic last_two;

   always_comb begin
      last_two = (div_cls_ff[NDIV-1] == CLS_TWO);
      for (int a = 0; a < NAXES; a++) begin
         // Edge 0 runs middle to high for two submerged vertices, else low to middle.
         if (last_two) begin
            dif_d[0][a] = {div_pos_ff[NDIV-1][VH+a][W-1], div_pos_ff[NDIV-1][VH+a]}
                        - {div_pos_ff[NDIV-1][VM+a][W-1], div_pos_ff[NDIV-1][VM+a]};
         end else begin
            dif_d[0][a] = {div_pos_ff[NDIV-1][VM+a][W-1], div_pos_ff[NDIV-1][VM+a]}
                        - {div_pos_ff[NDIV-1][VL+a][W-1], div_pos_ff[NDIV-1][VL+a]};
         end
         dif_d[1][a] = {div_pos_ff[NDIV-1][VH+a][W-1], div_pos_ff[NDIV-1][VH+a]}
                     - {div_pos_ff[NDIV-1][VL+a][W-1], div_pos_ff[NDIV-1][VL+a]};
         for (int e = 0; e < 2; e++) begin
            dif_neg_in[e][a] = dif_d[e][a][W];
            dif_mag_in[e][a] = dif_d[e][a][W] ? W'('0 - dif_d[e][a]) : dif_d[e][a][W-1:0];
         end
      end
   end

   // Products scaled back by the fraction's fractional bits.
   logic mul_vld_ff;
   class_type mul_cls_ff;
   logic [NPOS-1:0][W-1:0] mul_pos_ff;
   logic [1:0][NAXES-1:0] mul_neg_ff;
   logic [1:0][NAXES-1:0][W-1:0] mul_prod_ff, mul_prod_in;
   logic [1:0][NAXES-1:0][W+FRAC_W-1:0] mul_full;

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int a = 0; a < NAXES; a++) begin
            mul_full[e][a] = {{FRAC_W{1'b0}}, dif_mag_ff[e][a]} * {{W{1'b0}}, dif_t_ff[e]};
            mul_prod_in[e][a] = mul_full[e][a][W+FRAC_BITS-1:FRAC_BITS];
         end
      end
   end

   // Result register with cut points.
   logic out_vld_ff;
   class_type out_cls_ff;
   logic [NPOS-1:0][W-1:0] out_pos_ff;
   logic [1:0][NAXES-1:0][W-1:0] out_cut_ff, out_cut_in;
   logic [W-1:0] cut_start;
   logic phase_ff, phase_in;

   always_comb begin
      cut_start = '0;
      for (int e = 0; e < 2; e++) begin
         for (int a = 0; a < NAXES; a++) begin
            if (e == 0 && mul_cls_ff == CLS_TWO) begin
               cut_start = mul_pos_ff[VM+a];
            end else begin
               cut_start = mul_pos_ff[VL+a];
            end
            out_cut_in[e][a] = mul_neg_ff[e][a] ? cut_start - mul_prod_ff[e][a]
                                                : cut_start + mul_prod_ff[e][a];
         end
      end
   end

   // The pipeline moves as one; a two-piece triangle holds the result until both pieces are taken.
   assign adv = !out_vld_ff
             || (rsp.ready && !((out_cls_ff == CLS_TWO) && !phase_ff));
   assign job.ready = adv;

   always_comb begin
      phase_in = phase_ff;
      if (rsp.valid && rsp.ready) begin
         phase_in = (out_cls_ff == CLS_TWO) && !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_vld_ff <= 1'b0;
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (adv) begin
            dif_vld_ff <= div_vld_ff[NDIV-1];
            mul_vld_ff <= dif_vld_ff;
            out_vld_ff <= mul_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dif_cls_ff  <= div_cls_ff[NDIV-1];
         dif_pos_ff  <= div_pos_ff[NDIV-1];
         dif_t_ff    <= div_q_ff[NDIV-1];
         dif_neg_ff  <= dif_neg_in;
         dif_mag_ff  <= dif_mag_in;
         mul_cls_ff  <= dif_cls_ff;
         mul_pos_ff  <= dif_pos_ff;
         mul_neg_ff  <= dif_neg_ff;
         mul_prod_ff <= mul_prod_in;
         out_cls_ff  <= mul_cls_ff;
         out_pos_ff  <= mul_pos_ff;
         out_cut_ff  <= out_cut_in;
      end
   end

   logic [2:0][NAXES-1:0][W-1:0] corner;
   logic last;

   always_comb begin
      for (int a = 0; a < NAXES; a++) begin
         corner[2][a] = out_pos_ff[VL+a];
      end
      last = 1'b1;
      case (out_cls_ff)
         CLS_ONE: begin
            corner[0] = out_cut_ff[1];
            corner[1] = out_cut_ff[0];
         end
         CLS_TWO: begin
            if (phase_ff) begin
               corner[0] = out_cut_ff[0];
               corner[1] = out_cut_ff[1];
            end else begin
               for (int a = 0; a < NAXES; a++) begin
                  corner[0][a] = out_pos_ff[VM+a];
               end
               corner[1] = out_cut_ff[0];
               last = 1'b0;
            end
         end
         default: begin
            for (int a = 0; a < NAXES; a++) begin
               corner[0][a] = out_pos_ff[VH+a];
               corner[1][a] = out_pos_ff[VM+a];
            end
         end
      endcase
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.p0_x       = corner[0][0];
   assign rsp.p0_y       = corner[0][1];
   assign rsp.p0_z       = corner[0][2];
   assign rsp.p1_x       = corner[1][0];
   assign rsp.p1_y       = corner[1][1];
   assign rsp.p1_z       = corner[1][2];
   assign rsp.p2_x       = corner[2][0];
   assign rsp.p2_y       = corner[2][1];
   assign rsp.p2_z       = corner[2][2];
   assign rsp.last_piece = last;

`ifndef NO_ASSERTIONS
   a_phase_owner: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (out_vld_ff && out_cls_ff == CLS_TWO))
      else $error("second piece pending without a two-piece triangle");

   a_second_piece: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && out_cls_ff == CLS_TWO && !phase_ff)
      |=> (phase_ff && out_vld_ff))
      else $error("second piece of a two-piece triangle was dropped");

   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      !(out_vld_ff && out_cls_ff == CLS_NONE))
      else $error("triangle above the water reached the result register");
`endif

endmodule

// ----- rtl/triangle_waterline_clip.sv -----
// Top level of the triangle waterline clipper: front end, job queue and back end.
// Depends on twc_pkg, twc_if, twc_front, twc_queue and twc_back.
//
//   channel   direction   transaction
//   req_ch    in          one triangle: three vertices with position and height
//   rsp_ch    out         one submerged subtriangle and its last_piece flag
//
// A triangle passes the front register, the queue and a back pipeline of 17 divider
// stages plus three interpolation stages before its result. One triangle per cycle
// is taken while the back end does not stall; a triangle with two pieces holds the
// result register until both pieces are taken, and the back end stalls meanwhile.
// Triangles entirely above the water leave no result. Reset is synchronous and
// clears all valid state; a stalled rsp_ch stalls the back end, and the queue
// lets the front keep accepting until it is full.
module triangle_waterline_clip #(
   parameter int COORD_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   twc_req_if.sink req_ch,
   twc_rsp_if.source rsp_ch
);
   import twc_pkg::*;

   twc_job_if #(.COORD_WIDTH(COORD_WIDTH)) front_job ();
   twc_job_if #(.COORD_WIDTH(COORD_WIDTH)) back_job ();

   twc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .job   (front_job)
   );

   twc_queue #(.COORD_WIDTH(COORD_WIDTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (front_job),
      .rd    (back_job)
   );

   twc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock (clock),
      .reset (reset),
      .job   (back_job),
      .rsp   (rsp_ch)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for triangle_waterline_clip: drives triangles, predicts the
// submerged subtriangles and compares every field. Depends on every file in rtl/.
`timescale 1ns / 100ps
module tb;
   import twc_pkg::*;

   localparam int CW = 32;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type v [3][4];
   } tri_type;

   typedef struct {
      coord_type p [3][3];
      logic      last_piece;
   } piece_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   pieces_seen = 0;
   int   tris_sent = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   holdoff_cycles = 0;
   piece_type expected_pieces [$];

   twc_req_if #(.COORD_WIDTH(CW)) req_ch ();
   twc_rsp_if #(.COORD_WIDTH(CW)) rsp_ch ();

   triangle_waterline_clip #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   always #5 clock = ~clock;

   // Q1.16 fraction where the edge from lo (underwater) to hi crosses the surface.
   function automatic longint unsigned waterline_frac(longint hi, longint lo);
      longint unsigned num, den;
      num = longint'(-lo);
      den = longint'(hi - lo);
      return (num << 16) / den;
   endfunction

   function automatic longint cut_coord(longint s, longint e, longint unsigned t);
      longint d;
      longint unsigned mag, prod;
      d = e - s;
      mag = (d < 0) ? longint'(-d) : d;
      prod = (mag >> 16) * t + (((mag & 64'hFFFF) * t) >> 16);
      return (d < 0) ? s - longint'(prod) : s + longint'(prod);
   endfunction

   task automatic add_piece(input longint a [3], input longint b [3], input longint c [3],
                            input logic last);
      piece_type pc;
      for (int i = 0; i < 3; i++) begin
         pc.p[0][i] = coord_type'(a[i]);
         pc.p[1][i] = coord_type'(b[i]);
         pc.p[2][i] = coord_type'(c[i]);
      end
      pc.last_piece = last;
      expected_pieces.push_back(pc);
   endtask

   task automatic predict_submerged(input tri_type t);
      longint pos [3][3];
      longint h [3];
      longint c0 [3], c1 [3];
      int hi, mi, lo, sw;
      longint unsigned f0, f1;
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) pos[v][a] = longint'(t.v[v][a]);
         h[v] = longint'(t.v[v][3]);
      end
      hi = 0; mi = 1; lo = 2;
      if (h[lo] > h[hi]) begin sw = lo; lo = hi; hi = sw; end
      if (h[lo] > h[mi]) begin sw = lo; lo = mi; mi = sw; end
      if (h[mi] > h[hi]) begin sw = mi; mi = hi; hi = sw; end
      if (h[hi] >= 0 && h[mi] < 0 && h[lo] < 0) begin
         f0 = waterline_frac(h[hi], h[mi]);
         f1 = waterline_frac(h[hi], h[lo]);
         for (int a = 0; a < 3; a++) begin
            c0[a] = cut_coord(pos[mi][a], pos[hi][a], f0);
            c1[a] = cut_coord(pos[lo][a], pos[hi][a], f1);
         end
         add_piece(pos[mi], c0, pos[lo], 1'b0);
         add_piece(c0, c1, pos[lo], 1'b1);
      end else if (h[hi] >= 0 && h[mi] >= 0 && h[lo] < 0) begin
         f0 = waterline_frac(h[mi], h[lo]);
         f1 = waterline_frac(h[hi], h[lo]);
         for (int a = 0; a < 3; a++) begin
            c0[a] = cut_coord(pos[lo][a], pos[mi][a], f0);
            c1[a] = cut_coord(pos[lo][a], pos[hi][a], f1);
         end
         add_piece(c1, c0, pos[lo], 1'b1);
      end else if (h[hi] < 0) begin
         add_piece(pos[hi], pos[mi], pos[lo], 1'b1);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.a_x, req_ch.a_y, req_ch.a_z, req_ch.a_height} = '0;
      {req_ch.b_x, req_ch.b_y, req_ch.b_z, req_ch.b_height} = '0;
      {req_ch.c_x, req_ch.c_y, req_ch.c_z, req_ch.c_height} = '0;
   end

   // Sends one triangle; the prediction is made when the transaction is accepted.
   // Valid stays high after acceptance so that triangles can follow back to back.
   task automatic send_triangle(input tri_type t);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.a_x, req_ch.a_y, req_ch.a_z, req_ch.a_height} <=
         {t.v[0][0], t.v[0][1], t.v[0][2], t.v[0][3]};
      {req_ch.b_x, req_ch.b_y, req_ch.b_z, req_ch.b_height} <=
         {t.v[1][0], t.v[1][1], t.v[1][2], t.v[1][3]};
      {req_ch.c_x, req_ch.c_y, req_ch.c_z, req_ch.c_height} <=
         {t.v[2][0], t.v[2][1], t.v[2][2], t.v[2][3]};
      do @(posedge clock); while (!req_ch.ready);
      predict_submerged(t);
      tris_sent++;
      @(negedge clock);
   endtask

   // Receiver readiness: long hold-off when requested, otherwise random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         pieces_seen++;
         if (expected_pieces.size() == 0) begin
            $error("unexpected subtriangle transaction");
            errors++;
         end else begin
            piece_type e;
            coord_type got [3][3];
            e = expected_pieces.pop_front();
            got = '{'{rsp_ch.p0_x, rsp_ch.p0_y, rsp_ch.p0_z},
                    '{rsp_ch.p1_x, rsp_ch.p1_y, rsp_ch.p1_z},
                    '{rsp_ch.p2_x, rsp_ch.p2_y, rsp_ch.p2_z}};
            for (int k = 0; k < 3; k++)
               for (int a = 0; a < 3; a++)
                  if (got[k][a] !== e.p[k][a]) begin
                     $error("p%0d_%s expected %0d got %0d", k,
                            a == 0 ? "x" : (a == 1 ? "y" : "z"), e.p[k][a], got[k][a]);
                     errors++;
                  end
            if (rsp_ch.last_piece !== e.last_piece) begin
               $error("last_piece expected %0b got %0b", e.last_piece, rsp_ch.last_piece);
               errors++;
            end
         end
      end
   end

   function automatic coord_type rand_coord();
      case ($urandom_range(9, 0))
         0: return coord_type'({1'b1, {(CW-1){1'b0}}});
         1: return coord_type'({1'b0, {(CW-1){1'b1}}});
         2: return coord_type'(0);
         3, 4, 5: return coord_type'($urandom);
         default: return coord_type'($signed($urandom_range(200000, 0)) - 100000);
      endcase
   endfunction

   function automatic coord_type rand_height(int under);
      coord_type h;
      case ($urandom_range(7, 0))
         0: h = coord_type'($urandom);
         1: h = 0;
         default: h = coord_type'($urandom_range(5000, 1));
      endcase
      if (under == 1) h = (h == 0) ? -1 : -((h < 0) ? -(h + 1) : h);
      else if (under == 0 && h < 0) h = -(h + 1);
      return h;
   endfunction

   function automatic tri_type make_triangle(int n_under);
      tri_type t;
      int mask;
      case (n_under)
         0: mask = 0;
         1: mask = 1 << $urandom_range(2, 0);
         2: mask = 7 & ~(1 << $urandom_range(2, 0));
         default: mask = 7;
      endcase
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) t.v[v][a] = rand_coord();
         t.v[v][3] = rand_height((mask >> v) & 1);
      end
      return t;
   endfunction

   function automatic tri_type flat_triangle(coord_type p, coord_type ha, coord_type hb,
                                             coord_type hc);
      tri_type t;
      for (int v = 0; v < 3; v++)
         for (int a = 0; a < 3; a++) t.v[v][a] = coord_type'(p + v * 256 + a * 64);
      t.v[0][3] = ha; t.v[1][3] = hb; t.v[2][3] = hc;
      return t;
   endfunction

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (expected_pieces.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      coord_type mn, mx;
      tri_type t;
      mn = coord_type'({1'b1, {(CW-1){1'b0}}});
      mx = coord_type'({1'b0, {(CW-1){1'b1}}});
      send_triangle(flat_triangle(0, 10, 20, 30));        // all dry
      send_triangle(flat_triangle(100, -10, -20, -30));   // fully submerged
      send_triangle(flat_triangle(100, -5, -5, -5));      // equal heights
      send_triangle(flat_triangle(5, 0, 0, -1));          // zero height counts as dry
      send_triangle(flat_triangle(7, -1, 0, -1));         // cuts reach t = 1
      send_triangle(flat_triangle(9, 40, -20, 40));       // one vertex underwater
      send_triangle(flat_triangle(9, -40, 20, -30));      // one vertex above
      send_triangle(flat_triangle(3, mx, mn, 0));
      send_triangle(flat_triangle(3, mn, mn, mx));
      send_triangle(flat_triangle(3, mx, mx, mn));
      send_triangle(flat_triangle(3, mn, mn, mn));
      send_triangle(flat_triangle(3, mx, mx, mx));
      // Extreme positions across a cut in both directions.
      t = flat_triangle(0, mx, mn, -1);
      t.v[0][0] = mx; t.v[0][1] = mn; t.v[0][2] = mx;
      t.v[1][0] = mn; t.v[1][1] = mx; t.v[1][2] = mn;
      t.v[2][0] = mx; t.v[2][1] = mn; t.v[2][2] = 0;
      send_triangle(t);
      t.v[0][3] = 1; t.v[1][3] = mn; t.v[2][3] = mx;
      send_triangle(t);
      t.v[0][3] = -1; t.v[1][3] = mx; t.v[2][3] = mx;
      send_triangle(t);
      wait_drained();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) send_triangle(make_triangle($urandom_range(9, 0) == 0 ? 0
                                                 : $urandom_range(3, 1)));
      wait_drained();
   endtask

   // Receiver holds off long enough for the queue to fill and stall the input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      holdoff_cycles = 300;
      repeat (60) send_triangle(make_triangle($urandom_range(3, 1)));
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(300, 0, 0);
      test_random(300, 61, 0);
      test_random(300, 0, 61);
      test_random(300, 37, 37);
      test_backpressure();
      $display("Sent %0d triangles and checked %0d subtriangles across idle, stall and",
               tris_sent, pieces_seen);
      $display("hold-off phases, including extreme coordinates and zero heights.");
      if (errors == 0 && expected_pieces.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (expected_pieces.size() != 0)
            $error("%0d expected subtriangles never arrived", expected_pieces.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
